// ===== rtl/lbf_pkg.sv =====
// shared types and codes for the led blink and flash sequencer
// no dependencies; every other file of the block imports this package
package lbf_pkg;

  localparam int LBF_MAX_STEPS = 16;
  localparam int LBF_TIME_BITS = 16;

  // operation codes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // led modes and running modes
  localparam logic [1:0] MODE_STEADY = 2'd0;
  localparam logic [1:0] MODE_BLINK  = 2'd1;
  localparam logic [1:0] MODE_FLASH  = 2'd2;

  // register indexes on the apb port
  localparam logic [2:0] REG_LED_MODE     = 3'd0;
  localparam logic [2:0] REG_COLOR_RGB    = 3'd1;
  localparam logic [2:0] REG_BLINK_HALF   = 3'd2;
  localparam logic [2:0] REG_STEP_COUNT   = 3'd3;
  localparam logic [2:0] REG_FLASH_REPEAT = 3'd4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  step_index;
    logic [15:0] step_on_ms;
    logic [15:0] step_off_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] led_rgb;
    logic       flash_done;
    logic       sequence_active;
  } result_t;

  typedef struct packed {
    logic [1:0]  led_mode;
    logic [2:0]  color_rgb;
    logic [15:0] blink_half_period;
    logic [4:0]  flash_step_count;
    logic        flash_repeat;
  } cfg_t;

endpackage

// ===== rtl/lbf_cfg.sv =====
// apb register file of the led sequencer: mode, color, half period, step count, repeat
// depends on lbf_pkg
module lbf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lbf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lbf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output lbf_pkg::cfg_t                  cfg
);
  import lbf_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_mode          <= MODE_STEADY;
      cfg.color_rgb         <= 3'd0;
      cfg.blink_half_period <= 16'd500;
      cfg.flash_step_count  <= 5'd1;
      cfg.flash_repeat      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LED_MODE:     cfg.led_mode          <= pwdata[1:0];
        REG_COLOR_RGB:    cfg.color_rgb         <= pwdata[2:0];
        REG_BLINK_HALF:   cfg.blink_half_period <= pwdata[15:0];
        REG_STEP_COUNT:   cfg.flash_step_count  <= pwdata[4:0];
        REG_FLASH_REPEAT: cfg.flash_repeat      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LED_MODE:     prdata = {30'd0, cfg.led_mode};
      REG_COLOR_RGB:    prdata = {29'd0, cfg.color_rgb};
      REG_BLINK_HALF:   prdata = {16'd0, cfg.blink_half_period};
      REG_STEP_COUNT:   prdata = {27'd0, cfg.flash_step_count};
      REG_FLASH_REPEAT: prdata = {31'd0, cfg.flash_repeat};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/lbf_steps.sv =====
// flash step storage: on and off durations, one write port, one read address per array
// depends on lbf_pkg
module lbf_steps #(
  parameter int MAX_STEPS = lbf_pkg::LBF_MAX_STEPS,
  parameter int TIME_BITS = lbf_pkg::LBF_TIME_BITS,
  localparam int POS_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [POS_W-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0] wr_on,
  input  logic [TIME_BITS-1:0] wr_off,
  input  logic [POS_W-1:0]     on_addr,
  input  logic [POS_W-1:0]     off_addr,
  output logic [TIME_BITS-1:0] on_data,
  output logic [TIME_BITS-1:0] off_data
);
  import lbf_pkg::*;

  // no reset: the user must load an entry before it is read; the block does not enforce this
  logic [TIME_BITS-1:0] on_times  [MAX_STEPS];
  logic [TIME_BITS-1:0] off_times [MAX_STEPS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      on_times[wr_addr]  <= wr_on;
      off_times[wr_addr] <= wr_off;
    end
  end

  assign on_data  = on_times[on_addr];
  assign off_data = off_times[off_addr];

endmodule

// ===== rtl/lbf_core.sv =====
// sequencer core: input register, one-pass state update, result register
// depends on lbf_pkg; reads the step store through lbf_steps ports
module lbf_core #(
  parameter int MAX_STEPS = lbf_pkg::LBF_MAX_STEPS,
  parameter int TIME_BITS = lbf_pkg::LBF_TIME_BITS,
  localparam int POS_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lbf_pkg::cfg_t        cfg,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  lbf_pkg::item_t       item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output lbf_pkg::result_t     result,
  output logic                 st_wr_en,
  output logic [POS_W-1:0]     st_wr_addr,
  output logic [TIME_BITS-1:0] st_wr_on,
  output logic [TIME_BITS-1:0] st_wr_off,
  output logic [POS_W-1:0]     st_on_addr,
  output logic [POS_W-1:0]     st_off_addr,
  input  logic [TIME_BITS-1:0] st_on_data,
  input  logic [TIME_BITS-1:0] st_off_data
);
  import lbf_pkg::*;

  localparam int PW1 = POS_W + 1;

  // input register
  logic  pend_valid;
  item_t pend;
  logic  adv;
  logic  fire;

  // sequencer state
  logic [POS_W-1:0]     pos, pos_next;
  logic                 lit_phase, lit_phase_next;
  logic [TIME_BITS-1:0] ms_rem, ms_rem_next;
  logic [1:0]           run_mode, run_mode_next;
  logic                 blink_lit, blink_lit_next;
  logic [2:0]           led_drive, led_drive_next;
  logic                 done;

  logic [PW1-1:0]       n_use;
  logic [PW1-1:0]       pos_inc;
  logic                 wrap;
  logic                 walk_end;
  logic                 do_advance;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = pend_valid && !adv;
  assign fire       = pend_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!item_stall) begin
      pend_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      pend <= item;
    end
  end

  // steps in use: zero counts as one, saturates at the store depth
  always_comb begin
    if (cfg.flash_step_count == 5'd0) begin
      n_use = PW1'(1);
    end else if (32'(cfg.flash_step_count) > MAX_STEPS) begin
      n_use = PW1'(MAX_STEPS);
    end else begin
      n_use = PW1'(cfg.flash_step_count);
    end
  end

  assign pos_inc  = PW1'(pos) + PW1'(1);
  assign wrap     = (pos_inc >= n_use) && cfg.flash_repeat;
  assign walk_end = (pos_inc >= n_use) && !cfg.flash_repeat;

  // step store reads: off time of the current step, on time of the step entered
  assign st_off_addr = pos;
  assign st_on_addr  = (pend.operation == OP_START || wrap) ? '0 : pos_inc[POS_W-1:0];

  assign st_wr_en   = fire && (pend.operation == OP_LOAD) && (32'(pend.step_index) < MAX_STEPS);
  assign st_wr_addr = POS_W'(pend.step_index);
  assign st_wr_on   = TIME_BITS'(pend.step_on_ms);
  assign st_wr_off  = TIME_BITS'(pend.step_off_ms);

  always_comb begin
    pos_next       = pos;
    lit_phase_next = lit_phase;
    ms_rem_next    = ms_rem;
    run_mode_next  = run_mode;
    blink_lit_next = blink_lit;
    led_drive_next = led_drive;
    done           = 1'b0;
    do_advance     = 1'b0;
    case (pend.operation)
      OP_TICK: begin
        if (run_mode == MODE_BLINK || run_mode == MODE_FLASH) begin
          if (ms_rem > TIME_BITS'(1)) begin
            ms_rem_next = ms_rem - TIME_BITS'(1);
          end else if (run_mode == MODE_BLINK) begin
            blink_lit_next = !blink_lit;
            led_drive_next = blink_lit ? 3'd0 : cfg.color_rgb;
            ms_rem_next    = TIME_BITS'(cfg.blink_half_period);
          end else begin
            do_advance = 1'b1;
            if (lit_phase) begin
              led_drive_next = 3'd0;
              if (st_off_data != '0) begin
                lit_phase_next = 1'b0;
                ms_rem_next    = st_off_data;
                do_advance     = 1'b0;
              end
            end
          end
        end
        if (do_advance) begin
          if (walk_end) begin
            run_mode_next  = MODE_STEADY;
            led_drive_next = 3'd0;
            lit_phase_next = 1'b0;
            ms_rem_next    = '0;
            pos_next       = pos_inc[POS_W-1:0];
            done           = 1'b1;
          end else begin
            pos_next       = wrap ? '0 : pos_inc[POS_W-1:0];
            lit_phase_next = 1'b1;
            led_drive_next = cfg.color_rgb;
            ms_rem_next    = st_on_data;
          end
        end
      end
      OP_START: begin
        pos_next       = '0;
        lit_phase_next = 1'b0;
        blink_lit_next = 1'b0;
        ms_rem_next    = '0;
        led_drive_next = cfg.color_rgb;
        run_mode_next  = MODE_STEADY;
        if (cfg.led_mode == MODE_BLINK) begin
          run_mode_next  = MODE_BLINK;
          blink_lit_next = 1'b1;
          ms_rem_next    = TIME_BITS'(cfg.blink_half_period);
        end else if (cfg.led_mode == MODE_FLASH) begin
          run_mode_next  = MODE_FLASH;
          lit_phase_next = 1'b1;
          ms_rem_next    = st_on_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      lit_phase <= 1'b0;
      ms_rem    <= '0;
      run_mode  <= MODE_STEADY;
      blink_lit <= 1'b0;
      led_drive <= 3'd0;
    end else if (fire) begin
      pos       <= pos_next;
      lit_phase <= lit_phase_next;
      ms_rem    <= ms_rem_next;
      run_mode  <= run_mode_next;
      blink_lit <= blink_lit_next;
      led_drive <= led_drive_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.led_rgb         <= led_drive_next;
      result.flash_done      <= done;
      result.sequence_active <= (run_mode_next == MODE_BLINK) ||
                                (run_mode_next == MODE_FLASH);
    end
  end

`ifndef ASSERT_OFF
  a_done_goes_dark: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.flash_done |-> !result.sequence_active && result.led_rgb == 3'd0)
    else $error("flash done reported with led lit or sequence active");

  a_idle_no_timer: assert property (@(posedge clk) disable iff (rst)
    run_mode != MODE_BLINK && run_mode != MODE_FLASH |-> ms_rem == '0)
    else $error("timer left running while no sequence is active");

  a_gap_is_dark: assert property (@(posedge clk) disable iff (rst)
    run_mode == MODE_FLASH && !lit_phase |-> led_drive == 3'd0)
    else $error("led lit during a flash gap");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> pend_valid)
    else $error("accepted item missing from input register");
`endif

endmodule

// ===== rtl/led_blink_flash_sequencer_top.sv =====
// top level of the rgb led blink and flash sequencer
// depends on lbf_pkg, lbf_cfg, lbf_steps and lbf_core
//
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   lbf_pkg::item_t (operation, step fields)
// result    out        result_valid/result_stall lbf_pkg::result_t (led, done, active)
// apb       in/out     psel penable pwrite pready paddr[4:0], pwdata / prdata 32 bits
//
// one item per cycle while the result is not stalled; each item gives one result, held first in
// the input register and then, after one pass of state update, in the result register
// a stalled result holds the result register; item_stall is high only while the input
// register is full and the result is stalled, so it follows result_stall in the same cycle
// rst is synchronous: clears control state and registers, the step store is not cleared
// the user must write registers only while no item is in flight; the block does not enforce this
module led_blink_flash_sequencer_top #(
  parameter int MAX_STEPS = lbf_pkg::LBF_MAX_STEPS,
  parameter int TIME_BITS = lbf_pkg::LBF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  lbf_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output lbf_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lbf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lbf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import lbf_pkg::*;

  localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  cfg_t                 cfg;
  // step store port wires
  logic                 st_wr_en;
  logic [POS_W-1:0]     st_wr_addr;
  logic [TIME_BITS-1:0] st_wr_on;
  logic [TIME_BITS-1:0] st_wr_off;
  logic [POS_W-1:0]     st_on_addr;
  logic [POS_W-1:0]     st_off_addr;
  logic [TIME_BITS-1:0] st_on_data;
  logic [TIME_BITS-1:0] st_off_data;

  // register file, read live by the core
  lbf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // flash step durations, written by load items
  lbf_steps #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_steps (
    .clk      (clk),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_on    (st_wr_on),
    .wr_off   (st_wr_off),
    .on_addr  (st_on_addr),
    .off_addr (st_off_addr),
    .on_data  (st_on_data),
    .off_data (st_off_data)
  );

  // tick, load and start handling with the two pipeline registers
  lbf_core #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .st_wr_en     (st_wr_en),
    .st_wr_addr   (st_wr_addr),
    .st_wr_on     (st_wr_on),
    .st_wr_off    (st_wr_off),
    .st_on_addr   (st_on_addr),
    .st_off_addr  (st_off_addr),
    .st_on_data   (st_on_data),
    .st_off_data  (st_off_data)
  );

endmodule

// ===== tb/sv/tb_led_blink_flash_sequencer_top.sv =====
// self-checking testbench for led_blink_flash_sequencer_top: a directed table, then random phases
// an internal model of the led sequencer predicts every result; depends on lbf_pkg and the rtl
`timescale 1ns / 100ps

module tb_led_blink_flash_sequencer_top;
  import lbf_pkg::*;

  // codes the package leaves unnamed: the spare operation and the spare led mode
  localparam logic [1:0] OP_IGNORED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int QUIET_LIMIT  = 1000;
  localparam int REPORT_LINES = 30;

  // directed table: register writes, rows with a typed result, rows left to the model
  typedef enum logic [1:0] {ROW_REG, ROW_KNOWN, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  regsel;
    logic [15:0] regval;
    item_t       it;
    result_t     want;
  } dir_row_t;

  localparam int DIR_ROWS = 33;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // idle block: ticks change nothing, the spare operation is ignored, steady shows color 0
    '{ROW_KNOWN, '0, '0, '{OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF}, '{3'd0, 1'b0, 1'b0}},
    '{ROW_KNOWN, '0, '0, '{OP_IGNORED, 4'h0, 16'h0000, 16'h0000}, '{3'd0, 1'b0, 1'b0}},
    '{ROW_KNOWN, '0, '0, '{OP_START, 4'h0, 16'h0000, 16'h0000}, '{3'd0, 1'b0, 1'b0}},
    // blink with a zero half period toggles on every tick
    '{ROW_REG, REG_COLOR_RGB, 16'd7, '0, '0},
    '{ROW_REG, REG_LED_MODE, 16'(MODE_BLINK), '0, '0},
    '{ROW_REG, REG_BLINK_HALF, 16'd0, '0, '0},
    '{ROW_KNOWN, '0, '0, '{OP_START, 4'h0, 16'h0000, 16'h0000}, '{3'd7, 1'b0, 1'b1}},
    '{ROW_KNOWN, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '{3'd0, 1'b0, 1'b1}},
    '{ROW_KNOWN, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '{3'd7, 1'b0, 1'b1}},
    // loads at both ends of the table, with extreme and zero durations
    '{ROW_KNOWN, '0, '0, '{OP_LOAD, 4'hF, 16'hFFFF, 16'hFFFF}, '{3'd7, 1'b0, 1'b1}},
    '{ROW_KNOWN, '0, '0, '{OP_LOAD, 4'h0, 16'h0000, 16'h0000}, '{3'd7, 1'b0, 1'b1}},
    // flash restarted over a running blink, step count 0 means one step, zero on time
    '{ROW_REG, REG_LED_MODE, 16'(MODE_FLASH), '0, '0},
    '{ROW_REG, REG_STEP_COUNT, 16'd0, '0, '0},
    '{ROW_KNOWN, '0, '0, '{OP_START, 4'h0, 16'h0000, 16'h0000}, '{3'd7, 1'b0, 1'b1}},
    '{ROW_KNOWN, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '{3'd0, 1'b1, 1'b0}},
    '{ROW_KNOWN, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '{3'd0, 1'b0, 1'b0}},
    // the spare mode starts like steady
    '{ROW_REG, REG_LED_MODE, 16'(MODE_UNUSED), '0, '0},
    '{ROW_KNOWN, '0, '0, '{OP_START, 4'h0, 16'h0000, 16'h0000}, '{3'd7, 1'b0, 1'b0}},
    // repeating three-step walk, count lowered mid walk, then repeat cleared
    '{ROW_REG, REG_COLOR_RGB, 16'd5, '0, '0},
    '{ROW_REG, REG_LED_MODE, 16'(MODE_FLASH), '0, '0},
    '{ROW_REG, REG_STEP_COUNT, 16'd3, '0, '0},
    '{ROW_REG, REG_FLASH_REPEAT, 16'd1, '0, '0},
    '{ROW_ITEM, '0, '0, '{OP_LOAD, 4'h1, 16'h0001, 16'h0002}, '0},
    '{ROW_ITEM, '0, '0, '{OP_LOAD, 4'h2, 16'h0002, 16'h0000}, '0},
    '{ROW_ITEM, '0, '0, '{OP_START, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_REG, REG_STEP_COUNT, 16'd1, '0, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_REG, REG_FLASH_REPEAT, 16'd0, '0, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0},
    '{ROW_ITEM, '0, '0, '{OP_TICK, 4'h0, 16'h0000, 16'h0000}, '0}
  };

  // ---------------------------------------------------------------------------------------
  // block ports, all inputs at known values from time zero
  // ---------------------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr  = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  led_blink_flash_sequencer_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // sequencer model: its own copy of the registers and the led state
  // ---------------------------------------------------------------------------------------
  cfg_t        led_regs = '{MODE_STEADY, 3'd0, 16'd500, 5'd1, 1'b0};
  logic [15:0] on_tbl  [LBF_MAX_STEPS] = '{default: '0};
  logic [15:0] off_tbl [LBF_MAX_STEPS] = '{default: '0};
  int unsigned step_pos  = 0;     // wider than 4 bits: it may step past the last entry
  logic        lit_phase = 1'b0;
  logic [15:0] ms_left   = '0;
  logic [1:0]  run_mode  = MODE_STEADY;
  logic        blink_lit = 1'b0;
  logic [2:0]  led_drive = '0;

  result_t pending_leds [$];      // predicted results, oldest first

  bit  calm_phase = 1'b0;         // no gaps and no stalls while set
  int  mismatches = 0;
  int  items_sent = 0;
  int  starts     = 0;
  int  loads      = 0;
  int  results_seen = 0;
  int  walks_done = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;
  int unsigned stall_left = 0;

  // step count as the walk uses it: 0 acts as 1, anything above the table size saturates
  function automatic int unsigned steps_used();
    int unsigned n;
    n = 32'(led_regs.flash_step_count);
    if (n == 0) n = 1;
    if (n > LBF_MAX_STEPS) n = LBF_MAX_STEPS;
    return n;
  endfunction

  // next flash step; returns the done pulse when a non-repeating walk runs out
  function automatic logic next_flash_step();
    step_pos++;
    if (step_pos >= steps_used()) begin
      if (led_regs.flash_repeat) begin
        step_pos = 0;
      end else begin
        run_mode  = MODE_STEADY;
        led_drive = '0;
        lit_phase = 1'b0;
        ms_left   = '0;
        return 1'b1;
      end
    end
    lit_phase = 1'b1;
    led_drive = led_regs.color_rgb;
    ms_left   = on_tbl[step_pos];
    return 1'b0;
  endfunction

  // one millisecond tick; zero and one both run out on this tick
  function automatic logic led_tick();
    if (run_mode != MODE_BLINK && run_mode != MODE_FLASH) return 1'b0;
    if (ms_left > 1) begin
      ms_left--;
      return 1'b0;
    end
    if (run_mode == MODE_BLINK) begin
      blink_lit = !blink_lit;
      led_drive = blink_lit ? led_regs.color_rgb : 3'd0;
      ms_left   = led_regs.blink_half_period;
      return 1'b0;
    end
    if (lit_phase) begin
      led_drive = '0;
      // a zero dark time goes straight on to the next step
      if (off_tbl[step_pos] != 0) begin
        lit_phase = 1'b0;
        ms_left   = off_tbl[step_pos];
        return 1'b0;
      end
    end
    return next_flash_step();
  endfunction

  function automatic void start_led_mode();
    step_pos  = 0;
    lit_phase = 1'b0;
    blink_lit = 1'b0;
    ms_left   = '0;
    led_drive = led_regs.color_rgb;
    case (led_regs.led_mode)
      MODE_BLINK: begin
        run_mode  = MODE_BLINK;
        blink_lit = 1'b1;
        ms_left   = led_regs.blink_half_period;
      end
      MODE_FLASH: begin
        run_mode  = MODE_FLASH;
        lit_phase = 1'b1;
        ms_left   = on_tbl[0];
      end
      default: run_mode = MODE_STEADY;
    endcase
  endfunction

  // advances the model by one item and returns the outputs it then shows
  function automatic result_t led_outcome(input item_t nxt);
    result_t r;
    logic    done;
    done = 1'b0;
    case (nxt.operation)
      OP_TICK:  done = led_tick();
      OP_LOAD: begin
        on_tbl[nxt.step_index]  = nxt.step_on_ms;
        off_tbl[nxt.step_index] = nxt.step_off_ms;
      end
      OP_START: start_led_mode();
      default: ;
    endcase
    r.led_rgb         = led_drive;
    r.flash_done      = done;
    r.sequence_active = (run_mode == MODE_BLINK || run_mode == MODE_FLASH);
    return r;
  endfunction

  // mostly short durations so walks finish, now and then a full 16-bit value
  function automatic logic [15:0] draw_ms();
    if ($urandom_range(0, 99) < 6) return 16'($urandom);
    return 16'($urandom_range(0, 3));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------------------
  // item side: optional gap, then hold the transfer until it is taken
  // valid stays high after a transfer so back-to-back items need no extra assignment
  // ---------------------------------------------------------------------------------------
  task automatic push_item(input item_t nxt);
    int unsigned gap;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= nxt;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    items_sent++;
    if (nxt.operation == OP_START) starts++;
    if (nxt.operation == OP_LOAD) loads++;
    pending_leds.push_back(led_outcome(nxt));
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_leds.size() != 0);
  endtask

  // apb write: setup cycle, then access until pready; model register follows the same edge
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      REG_LED_MODE:     led_regs.led_mode          = val[1:0];
      REG_COLOR_RGB:    led_regs.color_rgb         = val[2:0];
      REG_BLINK_HALF:   led_regs.blink_half_period = val;
      REG_STEP_COUNT:   led_regs.flash_step_count  = val[4:0];
      REG_FLASH_REPEAT: led_regs.flash_repeat      = val[0];
      default: ;
    endcase
    // leave the bus idle before the next write or item
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // result side: check each transfer against the oldest prediction, then draw a stall
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t     want;
    int unsigned hold;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      results_seen++;
      if (pending_leds.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(result), 0);
      end else begin
        want = pending_leds.pop_front();
        if (result.led_rgb !== want.led_rgb)
          report_mismatch("led_rgb", 32'(result.led_rgb), 32'(want.led_rgb));
        if (result.flash_done !== want.flash_done)
          report_mismatch("flash_done", 32'(result.flash_done), 32'(want.flash_done));
        if (result.sequence_active !== want.sequence_active)
          report_mismatch("sequence_active", 32'(result.sequence_active),
                          32'(want.sequence_active));
      end
      if (result.flash_done === 1'b1) walks_done++;
      hold = calm_phase ? 0 : $urandom_range(0, 8);
      stall_left   <= hold;
      result_stall <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left   <= 0;
      result_stall <= 1'b0;
    end
  end

  // watchdog: any transfer on items, results or the register port keeps the run alive
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------------
  initial begin
    item_t       it;
    int          pick;
    int          start_pct;
    logic [1:0]  mode_v;
    logic [2:0]  color_v;
    logic [15:0] half_v;
    logic [4:0]  count_v;
    logic        rep_v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table; typed rows still run through the model to keep it in step
    foreach (DIR_TABLE[r]) begin
      if (DIR_TABLE[r].kind == ROW_REG) begin
        wait_drain();
        write_reg(DIR_TABLE[r].regsel, DIR_TABLE[r].regval);
      end else begin
        push_item(DIR_TABLE[r].it);
        if (DIR_TABLE[r].kind == ROW_KNOWN) pending_leds[$] = DIR_TABLE[r].want;
      end
    end

    // fill the whole table so any step count reads written entries only
    for (int i = 0; i < LBF_MAX_STEPS; i++) begin
      it.operation   = OP_LOAD;
      it.step_index  = 4'(i);
      it.step_on_ms  = draw_ms();
      it.step_off_ms = draw_ms();
      push_item(it);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      case (ph)
        // extremes first: long half period, saturating count, repeat on
        0: begin
          mode_v = MODE_FLASH; color_v = 3'd7; half_v = 16'hFFFF; count_v = 5'd31; rep_v = 1'b1;
        end
        1: begin
          mode_v = MODE_BLINK; color_v = 3'd1; half_v = 16'd0; count_v = 5'd0; rep_v = 1'b0;
        end
        2: begin
          mode_v = MODE_UNUSED; color_v = 3'd6; half_v = 16'd1; count_v = 5'd16; rep_v = 1'b0;
        end
        default: begin
          pick    = $urandom_range(0, 19);
          mode_v  = (pick < 8) ? MODE_FLASH : (pick < 14) ? MODE_BLINK :
                    (pick < 17) ? MODE_STEADY : MODE_UNUSED;
          color_v = 3'($urandom);
          half_v  = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 6)) : 16'($urandom);
          count_v = $urandom_range(0, 1) ? 5'($urandom_range(1, 16)) : 5'($urandom);
          rep_v   = 1'($urandom);
        end
      endcase
      write_reg(REG_LED_MODE, 16'(mode_v));
      write_reg(REG_COLOR_RGB, 16'(color_v));
      write_reg(REG_BLINK_HALF, half_v);
      write_reg(REG_STEP_COUNT, 16'(count_v));
      write_reg(REG_FLASH_REPEAT, 16'(rep_v));

      // every third phase streams with no gaps or stalls
      calm_phase = (ph % 3 == 2);
      // rare starts let long walks run to their end
      start_pct  = $urandom_range(2, 10);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick           = $urandom_range(0, 99);
        it.step_index  = 4'($urandom);
        it.step_on_ms  = 16'($urandom);
        it.step_off_ms = 16'($urandom);
        if (pick < start_pct) begin
          it.operation = OP_START;
        end else if (pick < start_pct + 12) begin
          it.operation   = OP_LOAD;
          it.step_on_ms  = draw_ms();
          it.step_off_ms = draw_ms();
        end else if (pick < start_pct + 17) begin
          it.operation = OP_IGNORED;
        end else begin
          it.operation = OP_TICK;
        end
        push_item(it);
      end
    end

    calm_phase = 1'b0;
    wait_drain();
    // wait on so a stray extra result would still show up
    repeat (8) @(posedge clk);

    $display("covered %0d item transfers (%0d starts, %0d table loads), %0d results checked",
             items_sent, starts, loads, results_seen);
    $display("%0d register writes over %0d random settings, %0d flash walks ran to their end",
             reg_writes, PHASES, walks_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lbf_pkg.sv
rtl/lbf_cfg.sv
rtl/lbf_steps.sv
rtl/lbf_core.sv
rtl/led_blink_flash_sequencer_top.sv
tb/sv/tb_led_blink_flash_sequencer_top.sv
